[hw/rtl/dq_pkg.sv]
package dq_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_DUMP       = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;          // Carry out a single-result command from the input.
        logic rd_issue;      // Read the next dump slot from the ring memory.
        logic out_load_dump; // Move the read word into the output register.
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic more;          // Dump words remain to be read.
        logic rd_pending;    // A read word waits for the output register.
        logic rd_last;       // The pending read word is the final one.
        logic out_free;      // The output register can take a word this cycle.
    } dp_status_t;

endpackage

[hw/rtl/dq_ctrl.sv]
module dq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dq_pkg::CMD_W-1:0]    command,
    input  dq_pkg::dp_status_t          dp_status,
    output dq_pkg::ctrl_cmd_t           ctrl_cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;
    logic           is_dump;
    logic           accept;

    assign is_dump = (dq_pkg::cmd_e_t'(command) == dq_pkg::CMD_DUMP);
    assign accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (accept && is_dump && !dp_status.empty)
                begin
                    state_next = dq_pkg::S_DUMP;
                end
            end
            dq_pkg::S_DUMP:
            begin
                if (dp_status.rd_pending && dp_status.out_free && dp_status.rd_last)
                begin
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready               = 1'b0;
        ctrl_cmd.exec          = 1'b0;
        ctrl_cmd.rd_issue      = 1'b0;
        ctrl_cmd.out_load_dump = 1'b0;
        case (state_reg)
            dq_pkg::S_IDLE:
            begin
                in_ready = dp_status.out_free;
                if (in_valid && dp_status.out_free)
                begin
                    // A dump of a non-empty queue starts by reading the front slot.
                    if (is_dump && !dp_status.empty)
                    begin
                        ctrl_cmd.rd_issue = 1'b1;
                    end
                    else
                    begin
                        ctrl_cmd.exec = 1'b1;
                    end
                end
            end
            dq_pkg::S_DUMP:
            begin
                ctrl_cmd.out_load_dump = dp_status.rd_pending && dp_status.out_free;
                ctrl_cmd.rd_issue      = dp_status.more
                                         && (!dp_status.rd_pending || dp_status.out_free);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/dq_datapath.sv]
module dq_datapath #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [dq_pkg::CMD_W-1:0]           command,
    input  logic signed [dq_pkg::DATA_W-1:0]   value,
    input  dq_pkg::ctrl_cmd_t                  ctrl_cmd,
    output dq_pkg::dp_status_t                 dp_status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [dq_pkg::STAT_W-1:0]          status,
    output logic signed [dq_pkg::DATA_W-1:0]   item,
    output logic [dq_pkg::OCC_W-1:0]           occupancy,
    output logic                               last
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic [dq_pkg::DATA_W-1:0] slots [DEPTH];

    logic [IW-1:0]             front_reg;
    logic [IW-1:0]             front_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             k_reg;
    logic [CW-1:0]             k_next;
    logic                      rd_pending_reg;
    logic                      rd_pending_next;
    logic                      rd_last_reg;
    logic                      rd_last_next;
    logic [dq_pkg::DATA_W-1:0] rd_data_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    dq_pkg::status_t           status_reg;
    dq_pkg::status_t           status_next;
    logic [dq_pkg::DATA_W-1:0] item_reg;
    logic [dq_pkg::DATA_W-1:0] item_next;
    logic [CW-1:0]             occ_reg;
    logic [CW-1:0]             occ_next;
    logic                      last_reg;
    logic                      last_next;

    logic                      full;
    logic                      empty;
    logic                      out_free;
    logic [IW-1:0]             front_dec;
    logic [IW-1:0]             front_inc;
    logic [SW-1:0]             back_sum;
    logic [IW-1:0]             back_addr;
    logic [SW-1:0]             rd_sum;
    logic [IW-1:0]             rd_addr;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
    assign front_inc = (front_reg == IW'(DEPTH - 1)) ? '0 : front_reg + IW'(1);

    // Sums stay below twice the depth, so one conditional subtract wraps them.
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_addr = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
    assign rd_sum    = SW'(front_reg) + SW'(k_reg);
    assign rd_addr   = (rd_sum >= SW'(DEPTH)) ? IW'(rd_sum - SW'(DEPTH)) : IW'(rd_sum);

    assign dp_status.empty      = empty;
    assign dp_status.more       = (k_reg < count_reg);
    assign dp_status.rd_pending = rd_pending_reg;
    assign dp_status.rd_last    = rd_last_reg;
    assign dp_status.out_free   = out_free;

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        rd_pending_next = rd_pending_reg;
        rd_last_next    = rd_last_reg;
        wr_en           = 1'b0;
        wr_addr         = back_addr;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        item_next       = item_reg;
        occ_next        = occ_reg;
        last_next       = last_reg;

        if (ctrl_cmd.out_load_dump)
        begin
            rd_pending_next = 1'b0;
            out_valid_next  = 1'b1;
            status_next     = dq_pkg::STAT_OK;
            item_next       = rd_data_reg;
            occ_next        = count_reg;
            last_next       = rd_last_reg;
            if (rd_last_reg)
            begin
                k_next = '0;
            end
        end

        if (ctrl_cmd.rd_issue)
        begin
            rd_pending_next = 1'b1;
            rd_last_next    = (k_reg + CW'(1) == count_reg);
            k_next          = k_reg + CW'(1);
        end

        if (ctrl_cmd.exec)
        begin
            out_valid_next = 1'b1;
            status_next    = dq_pkg::STAT_OK;
            item_next      = '0;
            last_next      = 1'b1;
            case (dq_pkg::cmd_e_t'(command))
                dq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = dq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_addr;
                        count_next = count_reg + CW'(1);
                    end
                end
                dq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = dq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                dq_pkg::CMD_DUMP:
                begin
                    // Only an empty dump comes here; a non-empty one streams.
                    status_next = dq_pkg::STAT_EMPTY;
                end
                dq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = dq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                dq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = dq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = dq_pkg::STAT_OK;
                end
            endcase
            occ_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            rd_pending_reg <= rd_pending_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots[wr_addr] <= value;
        end
        if (ctrl_cmd.rd_issue)
        begin
            rd_data_reg <= slots[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign item      = item_reg;
    assign occupancy = dq_pkg::OCC_W'(occ_reg);
    assign last      = last_reg;

endmodule

[hw/rtl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words in a ring memory of DEPTH slots.
// A push, a pop, an empty dump or an unused command code yields a single
// registered word; outside a dump the input is ready whenever the output
// register is empty or is being read. A dump of n stored words streams them
// front to back at one word per cycle while the receiver keeps taking them,
// each word passing the registered read port of the ring memory and then the
// output register, and blocks new commands until its last word is loaded there.
// A push on a full queue is refused with a full status, and a pop or dump on
// an empty queue reports empty. The memory needs no clearing after reset.
module double_ended_queue #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dq_pkg::CMD_W-1:0]           command,
    input  logic signed [dq_pkg::DATA_W-1:0]   value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dq_pkg::STAT_W-1:0]          status,
    output logic signed [dq_pkg::DATA_W-1:0]   item,
    output logic [dq_pkg::OCC_W-1:0]           occupancy,
    output logic                               last
);

    dq_pkg::ctrl_cmd_t  ctrl_cmd;
    dq_pkg::dp_status_t dp_status;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (command),
        .value     (value),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .status    (status),
        .item      (item),
        .occupancy (occupancy),
        .last      (last)
    );

endmodule

[verif/tb_double_ended_queue.sv]
module tb_double_ended_queue;

    localparam int DEPTH = 64;

    // Command codes the block does not decode; each one still returns a single ok word.
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [dq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam logic signed [dq_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [dq_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [dq_pkg::STAT_W-1:0]        status;
        logic signed [dq_pkg::DATA_W-1:0] item;
        logic [dq_pkg::OCC_W-1:0]         occupancy;
        logic                             last;
    } dq_word_t;

    // One directed command. When typed is set, the single result word is the
    // status and occupancy given here, with item 0 and last 1.
    typedef struct packed {
        logic [dq_pkg::CMD_W-1:0]         cmd;
        logic signed [dq_pkg::DATA_W-1:0] val;
        logic                             typed;
        logic [dq_pkg::STAT_W-1:0]        status;
        logic [dq_pkg::OCC_W-1:0]         occupancy;
    } dq_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    logic [dq_pkg::CMD_W-1:0]            command;
    logic signed [dq_pkg::DATA_W-1:0]    value;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [dq_pkg::STAT_W-1:0]           status;
    logic signed [dq_pkg::DATA_W-1:0]    item;
    logic [dq_pkg::OCC_W-1:0]            occupancy;
    logic                                last;

    // Typed expectation that travels with the word currently offered.
    logic                                row_typed;
    dq_word_t                            row_word;

    dq_word_t                            expected_words[$];
    dq_row_t                             directed_rows[$];

    // Shadow copy of the ring.
    logic signed [dq_pkg::DATA_W-1:0]    ring_words[DEPTH];
    int                                  ring_front = 0;
    int                                  ring_fill = 0;

    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int dump_count = 0;
    int full_count = 0;
    int empty_count = 0;
    int peak_fill = 0;
    int burst_left = 0;
    int ready_left = 0;
    int ready_mode = 0;
    int ready_phase = 0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .value    (value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .item     (item),
        .occupancy(occupancy),
        .last     (last)
    );

    always #5 clk = ~clk;

    task automatic queue_expected(input logic [dq_pkg::STAT_W-1:0] st,
                                  input logic signed [dq_pkg::DATA_W-1:0] data,
                                  input logic fin);
        dq_word_t w;
        w.status    = st;
        w.item      = data;
        w.occupancy = dq_pkg::OCC_W'(ring_fill);
        w.last      = fin;
        expected_words.push_back(w);
    endtask

    // Applies one command to the shadow ring and queues the words it produces.
    task automatic predict_command(input logic [dq_pkg::CMD_W-1:0] cmd,
                                   input logic signed [dq_pkg::DATA_W-1:0] val);
        int k;
        case (cmd)
            dq_pkg::CMD_PUSH_BACK, dq_pkg::CMD_PUSH_FRONT:
            begin
                if (ring_fill >= DEPTH)
                begin
                    full_count++;
                    queue_expected(dq_pkg::STAT_FULL, '0, 1'b1);
                end
                else
                begin
                    if (cmd == dq_pkg::CMD_PUSH_BACK)
                        ring_words[(ring_front + ring_fill) % DEPTH] = val;
                    else
                    begin
                        ring_front = (ring_front + DEPTH - 1) % DEPTH;
                        ring_words[ring_front] = val;
                    end
                    ring_fill++;
                    if (ring_fill > peak_fill)
                        peak_fill = ring_fill;
                    queue_expected(dq_pkg::STAT_OK, '0, 1'b1);
                end
            end
            dq_pkg::CMD_DUMP:
            begin
                dump_count++;
                if (ring_fill == 0)
                begin
                    empty_count++;
                    queue_expected(dq_pkg::STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (k = 0; k < ring_fill; k++)
                        queue_expected(dq_pkg::STAT_OK, ring_words[(ring_front + k) % DEPTH],
                                       k == ring_fill - 1);
                end
            end
            dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK:
            begin
                if (ring_fill == 0)
                begin
                    empty_count++;
                    queue_expected(dq_pkg::STAT_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (cmd == dq_pkg::CMD_POP_FRONT)
                        ring_front = (ring_front + 1) % DEPTH;
                    ring_fill--;
                    queue_expected(dq_pkg::STAT_OK, '0, 1'b1);
                end
            end
            default:
                queue_expected(dq_pkg::STAT_OK, '0, 1'b1);
        endcase
    endtask

    // Both handshakes are sampled here, before the block's registers update.
    always @(posedge clk)
    begin : monitor
        dq_word_t got;
        dq_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, item, occupancy, last};
                words_out++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word: status %0d item %0d occupancy %0d last %0d",
                             $time, got.status, $signed(got.item), got.occupancy, got.last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: mismatch: expected status %0d item %0d",
                                  " occupancy %0d last %0d"},
                                 $time, want.status, $signed(want.item), want.occupancy,
                                 want.last);
                        $display({"%0t:           actual   status %0d item %0d",
                                  " occupancy %0d last %0d"},
                                 $time, got.status, $signed(got.item), got.occupancy,
                                 got.last);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_command(command, value);
                if (row_typed)
                    expected_words[expected_words.size() - 1] = row_word;
                words_in++;
            end
        end
    end

    // Receiver: switches between stretches of full rate, light and heavy
    // stalls, and a fixed two-of-three pattern.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: out_ready = 1'b1;
            1: out_ready = ($urandom_range(0, 3) != 0);
            2: out_ready = ((ready_phase % 3) != 0);
            default: out_ready = ($urandom_range(0, 2) == 0);
        endcase
    end

    // Offers one word at a falling edge and returns at the falling edge after
    // it was taken. Gaps come only between bursts.
    task automatic send_word(input logic [dq_pkg::CMD_W-1:0] cmd,
                             input logic signed [dq_pkg::DATA_W-1:0] val,
                             input logic typed,
                             input dq_word_t typed_word);
        int gap;
        int seen;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        command   = cmd;
        value     = val;
        row_typed = typed;
        row_word  = typed_word;
        seen = words_in;
        while (words_in == seen)
            @(negedge clk);
    endtask

    function automatic logic signed [dq_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 11))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [dq_pkg::CMD_W-1:0] random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return dq_pkg::CMD_PUSH_BACK;
        else if (pick < 45)
            return dq_pkg::CMD_PUSH_FRONT;
        else if (pick < 55)
            return dq_pkg::CMD_DUMP;
        else if (pick < 70)
            return dq_pkg::CMD_POP_FRONT;
        else if (pick < 85)
            return dq_pkg::CMD_POP_BACK;
        else if (pick < 88)
            return CMD_SPARE_5;
        else if (pick < 91)
            return CMD_SPARE_6;
        else if (pick < 94)
            return CMD_SPARE_7;
        else
            return dq_pkg::CMD_PUSH_BACK;
    endfunction

    task automatic send_random_mix(input int count);
        repeat (count)
            send_word(random_command(), random_value(), 1'b0, '0);
    endtask

    // Fills the ring to the top with pushes at both ends and an occasional dump,
    // knocks on the full limit, dumps all of it, then pops a dozen words from both ends.
    task automatic send_fill_to_full();
        while (ring_fill < DEPTH)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(dq_pkg::CMD_DUMP, random_value(), 1'b0, '0);
            else
                send_word($urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT
                                               : dq_pkg::CMD_PUSH_BACK,
                          random_value(), 1'b0, '0);
        end
        send_word(dq_pkg::CMD_PUSH_BACK, random_value(), 1'b0, '0);
        send_word(dq_pkg::CMD_PUSH_FRONT, random_value(), 1'b0, '0);
        send_word(dq_pkg::CMD_DUMP, random_value(), 1'b0, '0);
        repeat (12)
            send_word($urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK,
                      random_value(), 1'b0, '0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = dq_pkg::CMD_PUSH_BACK;
        value     = '0;
        row_typed = 1'b0;
        row_word  = '0;

        directed_rows.push_back('{dq_pkg::CMD_DUMP,       '0,       1'b1, dq_pkg::STAT_EMPTY,
                                  7'd0});
        directed_rows.push_back('{dq_pkg::CMD_POP_FRONT,  '0,       1'b1, dq_pkg::STAT_EMPTY,
                                  7'd0});
        directed_rows.push_back('{dq_pkg::CMD_POP_BACK,   '0,       1'b1, dq_pkg::STAT_EMPTY,
                                  7'd0});
        directed_rows.push_back('{CMD_SPARE_5,            WORD_MAX, 1'b1, dq_pkg::STAT_OK,
                                  7'd0});
        // A push at the front of the empty ring wraps the front to the top slot.
        directed_rows.push_back('{dq_pkg::CMD_PUSH_FRONT, WORD_MIN, 1'b1, dq_pkg::STAT_OK,
                                  7'd1});
        directed_rows.push_back('{dq_pkg::CMD_PUSH_BACK,  WORD_MAX, 1'b1, dq_pkg::STAT_OK,
                                  7'd2});
        directed_rows.push_back('{dq_pkg::CMD_PUSH_BACK,  '0,       1'b1, dq_pkg::STAT_OK,
                                  7'd3});
        directed_rows.push_back('{dq_pkg::CMD_PUSH_FRONT, -32'sd1,  1'b1, dq_pkg::STAT_OK,
                                  7'd4});
        directed_rows.push_back('{dq_pkg::CMD_DUMP,       '0,       1'b0, dq_pkg::STAT_OK,
                                  7'd0});
        directed_rows.push_back('{CMD_SPARE_6,            32'sh5555_5555, 1'b1, dq_pkg::STAT_OK,
                                  7'd4});
        directed_rows.push_back('{CMD_SPARE_7,            32'shAAAA_AAAA, 1'b1, dq_pkg::STAT_OK,
                                  7'd4});
        directed_rows.push_back('{dq_pkg::CMD_POP_FRONT,  '0,       1'b1, dq_pkg::STAT_OK,
                                  7'd3});
        directed_rows.push_back('{dq_pkg::CMD_POP_BACK,   WORD_MIN, 1'b1, dq_pkg::STAT_OK,
                                  7'd2});
        directed_rows.push_back('{dq_pkg::CMD_DUMP,       '0,       1'b0, dq_pkg::STAT_OK,
                                  7'd0});
        directed_rows.push_back('{dq_pkg::CMD_PUSH_FRONT, 32'sd1,   1'b1, dq_pkg::STAT_OK,
                                  7'd3});
        directed_rows.push_back('{dq_pkg::CMD_POP_BACK,   '0,       1'b1, dq_pkg::STAT_OK,
                                  7'd2});
        directed_rows.push_back('{dq_pkg::CMD_POP_BACK,   '0,       1'b1, dq_pkg::STAT_OK,
                                  7'd1});
        directed_rows.push_back('{dq_pkg::CMD_POP_FRONT,  '0,       1'b1, dq_pkg::STAT_OK,
                                  7'd0});
        directed_rows.push_back('{dq_pkg::CMD_DUMP,       '0,       1'b1, dq_pkg::STAT_EMPTY,
                                  7'd0});
        directed_rows.push_back('{dq_pkg::CMD_POP_BACK,   WORD_MAX, 1'b1, dq_pkg::STAT_EMPTY,
                                  7'd0});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].val, directed_rows[i].typed,
                      '{directed_rows[i].status, '0, directed_rows[i].occupancy, 1'b1});

        send_random_mix(15);
        send_fill_to_full();
        send_random_mix(12);
        in_valid = 1'b0;

        wait (expected_words.size() == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d commands, checked %0d result words over %0d dumps.",
                 words_in, words_out, dump_count);
        $display("Ring peaked at %0d of %0d; %0d pushes refused, %0d empty reports.",
                 peak_fill, DEPTH, full_count, empty_count);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d result words still due.", expected_words.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
verif/tb_double_ended_queue.sv
